>>> rtl/rhr_pkg.sv
// rhr_pkg: payload structs, sideband struct and fixed constants for the hue rotator
// no dependencies; used by rgb_hue_rotate and tb
package rhr_pkg;

    localparam int SECTOR_DEG  = 60;
    localparam int SHIFT_W     = 14;
    localparam int SCALED_W    = 12;
    localparam int RECIP_W     = 13;
    localparam int RECIP15_MUL = 4370;
    localparam int RECIP_SHIFT = 16;

    typedef struct packed {
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
    } t_pix_out;

    typedef enum logic [1:0] {
        MAX_RED,
        MAX_GREEN,
        MAX_BLUE
    } t_max_sel;

    typedef struct packed {
        t_pix_in    pix;
        logic [7:0] mx;
        logic [7:0] mn;
        logic [7:0] delta;
        t_max_sel   sel;
        logic       neg;
        logic       gray;
    } t_side;

endpackage

>>> rtl/rgb_hue_rotate.sv
// rgb_hue_rotate: HSV hue rotation of one 8-bit RGB pixel per clock
// depends on rhr_pkg and rhr_div
// throughput: one pixel per cycle, busy never rises and the result side never stalls
// pipeline: stage 1, the divider stages, stages a to e and the result register; o_valid marks one cycle
// reset: synchronous active low, empties the pipeline and clears hue shift to zero
module rgb_hue_rotate
    import rhr_pkg::*;
#(
    parameter int HUE_FRAC_BITS = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  t_pix_in            i_pixel,
    output logic               o_valid,
    output t_pix_out           o_result,
    input  logic               i_cfg_we,
    input  logic [SHIFT_W-1:0] i_cfg_data
);

    localparam int SECTOR  = SECTOR_DEG << HUE_FRAC_BITS;
    localparam int CIRCLE  = 6 * SECTOR;
    localparam int HW      = $clog2(CIRCLE);
    localparam int QW      = $clog2(SECTOR + 1);
    localparam int WW      = QW + 8;
    localparam int PW      = QW + 8;
    localparam int MW      = SCALED_W + RECIP_W;
    localparam int SHIFT_M = (2 ** (SHIFT_W - 1) + CIRCLE - 1) / CIRCLE;
    localparam int KS      = $clog2(2 * SHIFT_M);
    localparam int TW      = $clog2(2 ** (SHIFT_W - 1) + 2 * SHIFT_M * CIRCLE) + 1;

    typedef enum logic [2:0] {
        SEC_RED,
        SEC_YELLOW,
        SEC_GREEN,
        SEC_CYAN,
        SEC_BLUE,
        SEC_MAGENTA
    } t_sector;

    logic [HW-1:0] r_shift_mod;
    logic [HW-1:0] n_shift_mod;

    // config: wrap the signed shift into one circle at write time
    always_comb begin
        logic [TW-1:0] t;
        t = TW'($signed(i_cfg_data)) + TW'(SHIFT_M * CIRCLE);
        for (int k = KS - 1; k >= 0; k--) begin
            if (t >= TW'(CIRCLE << k)) begin
                t = t - TW'(CIRCLE << k);
            end
        end
        n_shift_mod = HW'(t);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift_mod <= '0;
        end else if (i_cfg_we) begin
            r_shift_mod <= n_shift_mod;
        end
    end

    assign busy = 1'b0;

    // stage 1: max, min, sector of max, numerator
    t_side         n_s1_side;
    logic [WW-1:0] n_s1_dividend;
    t_side         r_s1_side;
    logic [WW-1:0] r_s1_dividend;
    logic          r_s1_valid;

    always_comb begin
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] mx;
        logic [7:0] mn;
        logic [7:0] num;
        r  = i_pixel.in_red;
        g  = i_pixel.in_green;
        b  = i_pixel.in_blue;
        mx = r;
        mn = r;
        if (g > mx) begin
            mx = g;
        end
        if (b > mx) begin
            mx = b;
        end
        if (g < mn) begin
            mn = g;
        end
        if (b < mn) begin
            mn = b;
        end
        n_s1_side.pix   = i_pixel;
        n_s1_side.mx    = mx;
        n_s1_side.mn    = mn;
        n_s1_side.delta = mx - mn;
        n_s1_side.gray  = (mx == mn);
        if (r == mx) begin
            n_s1_side.sel = MAX_RED;
            n_s1_side.neg = (g < b);
            num           = (g < b) ? (b - g) : (g - b);
        end else if (g == mx) begin
            n_s1_side.sel = MAX_GREEN;
            n_s1_side.neg = (b < r);
            num           = (b < r) ? (r - b) : (b - r);
        end else begin
            n_s1_side.sel = MAX_BLUE;
            n_s1_side.neg = (r < g);
            num           = (r < g) ? (g - r) : (r - g);
        end
        n_s1_dividend = (WW'(num) * WW'(SECTOR_DEG)) << HUE_FRAC_BITS;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= start && !busy;
        end
        r_s1_side     <= n_s1_side;
        r_s1_dividend <= n_s1_dividend;
    end

    // divider stages
    logic          dv_valid;
    logic [QW-1:0] dv_quot;
    t_side         dv_side;

    rhr_div #(
        .QUOT_W (QW),
        .SIDE_W ($bits(t_side))
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_s1_valid),
        .i_dividend (r_s1_dividend),
        .i_divisor  (r_s1_side.delta),
        .i_side     (r_s1_side),
        .o_valid    (dv_valid),
        .o_quot     (dv_quot),
        .o_side     (dv_side)
    );

    // stage a: hue of the input
    logic          r_a_valid;
    logic [HW-1:0] r_a_hue;
    t_side         r_a_side;
    logic [HW-1:0] n_a_hue;

    always_comb begin
        logic [HW-1:0] base;
        logic [HW-1:0] hraw;
        case (dv_side.sel)
            MAX_RED:   base = dv_side.neg ? HW'(CIRCLE) : '0;
            MAX_GREEN: base = HW'(2 * SECTOR);
            MAX_BLUE:  base = HW'(4 * SECTOR);
            default:   base = '0;
        endcase
        if (dv_side.neg) begin
            hraw = base - HW'(dv_quot);
        end else begin
            hraw = base + HW'(dv_quot);
        end
        n_a_hue = (hraw == HW'(CIRCLE)) ? '0 : hraw;
    end

    // stage b: add shift and wrap
    logic          r_b_valid;
    logic [HW-1:0] r_b_hue;
    t_side         r_b_side;
    logic [HW-1:0] n_b_hue;
    logic [HW:0]   b_sum;

    always_comb begin
        b_sum = {1'b0, r_a_hue} + {1'b0, r_shift_mod};
        if (b_sum >= (HW + 1)'(CIRCLE)) begin
            b_sum = b_sum - (HW + 1)'(CIRCLE);
        end
        n_b_hue = HW'(b_sum);
    end

    // stage c: sector and position within it
    logic          r_c_valid;
    t_sector       r_c_sec;
    logic [QW-1:0] r_c_p;
    t_side         r_c_side;
    t_sector       n_c_sec;
    logic [QW-1:0] n_c_p;

    always_comb begin
        logic [HW-1:0] f;
        if (r_b_hue >= HW'(5 * SECTOR)) begin
            n_c_sec = SEC_MAGENTA;
            f       = r_b_hue - HW'(5 * SECTOR);
        end else if (r_b_hue >= HW'(4 * SECTOR)) begin
            n_c_sec = SEC_BLUE;
            f       = r_b_hue - HW'(4 * SECTOR);
        end else if (r_b_hue >= HW'(3 * SECTOR)) begin
            n_c_sec = SEC_CYAN;
            f       = r_b_hue - HW'(3 * SECTOR);
        end else if (r_b_hue >= HW'(2 * SECTOR)) begin
            n_c_sec = SEC_GREEN;
            f       = r_b_hue - HW'(2 * SECTOR);
        end else if (r_b_hue >= HW'(SECTOR)) begin
            n_c_sec = SEC_YELLOW;
            f       = r_b_hue - HW'(SECTOR);
        end else begin
            n_c_sec = SEC_RED;
            f       = r_b_hue;
        end
        if (n_c_sec[0]) begin
            n_c_p = QW'(SECTOR) - QW'(f);
        end else begin
            n_c_p = QW'(f);
        end
    end

    // stage d: delta times position
    logic          r_d_valid;
    t_sector       r_d_sec;
    logic [PW-1:0] r_d_prod;
    t_side         r_d_side;

    // stage e: divide by the sector size, shift then reciprocal of 15
    logic          r_e_valid;
    t_sector       r_e_sec;
    logic [7:0]    r_e_frac;
    t_side         r_e_side;
    logic [SCALED_W-1:0] e_scaled;
    logic [MW-1:0]       e_mul;

    assign e_scaled = SCALED_W'(r_d_prod >> (HUE_FRAC_BITS + 2));
    assign e_mul    = MW'(e_scaled) * MW'(RECIP15_MUL);

    // output stage
    logic       r_out_valid;
    t_pix_out   r_out;
    t_pix_out   n_out;

    always_comb begin
        logic [7:0] mid;
        logic [7:0] mx;
        logic [7:0] mn;
        mx  = r_e_side.mx;
        mn  = r_e_side.mn;
        mid = mn + r_e_frac;
        case (r_e_sec)
            SEC_RED:     n_out = '{out_red: mx,  out_green: mid, out_blue: mn};
            SEC_YELLOW:  n_out = '{out_red: mid, out_green: mx,  out_blue: mn};
            SEC_GREEN:   n_out = '{out_red: mn,  out_green: mx,  out_blue: mid};
            SEC_CYAN:    n_out = '{out_red: mn,  out_green: mid, out_blue: mx};
            SEC_BLUE:    n_out = '{out_red: mid, out_green: mn,  out_blue: mx};
            default:     n_out = '{out_red: mx,  out_green: mn,  out_blue: mid};
        endcase
        if (r_e_side.gray) begin
            n_out = '{out_red:   r_e_side.pix.in_red,
                      out_green: r_e_side.pix.in_green,
                      out_blue:  r_e_side.pix.in_blue};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_d_valid   <= 1'b0;
            r_e_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_a_valid   <= dv_valid;
            r_b_valid   <= r_a_valid;
            r_c_valid   <= r_b_valid;
            r_d_valid   <= r_c_valid;
            r_e_valid   <= r_d_valid;
            r_out_valid <= r_e_valid;
        end
        r_a_hue  <= n_a_hue;
        r_a_side <= dv_side;
        r_b_hue  <= n_b_hue;
        r_b_side <= r_a_side;
        r_c_sec  <= n_c_sec;
        r_c_p    <= n_c_p;
        r_c_side <= r_b_side;
        r_d_sec  <= r_c_sec;
        r_d_prod <= PW'(r_c_side.delta) * PW'(r_c_p);
        r_d_side <= r_c_side;
        r_e_sec  <= r_d_sec;
        r_e_frac <= 8'(e_mul >> RECIP_SHIFT);
        r_e_side <= r_d_side;
        r_out    <= n_out;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    a_shift_wrapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_shift_mod < HW'(CIRCLE))
        else $error("wrapped hue shift outside one circle");

    a_hue_wrapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> (r_b_hue < HW'(CIRCLE)))
        else $error("rotated hue outside one circle");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_valid |-> (r_c_p <= QW'(SECTOR)))
        else $error("sector position exceeds sector size");

    a_mid_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_e_valid |-> (r_e_frac <= r_e_side.delta))
        else $error("middle component passes the maximum");

endmodule

>>> rtl/rhr_div.sv
// rhr_div: pipelined restoring divider, two quotient bits per stage, sideband carried along
// generic unsigned dividend by 8-bit divisor; quotient must fit QUOT_W bits
module rhr_div #(
    parameter int QUOT_W = 10,
    parameter int SIDE_W = 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [QUOT_W+7:0]   i_dividend,
    input  logic [7:0]          i_divisor,
    input  logic [SIDE_W-1:0]   i_side,
    output logic                o_valid,
    output logic [QUOT_W-1:0]   o_quot,
    output logic [SIDE_W-1:0]   o_side
);

    localparam int WW  = QUOT_W + 8;
    localparam int BPS = 2;
    localparam int ND  = (QUOT_W + BPS - 1) / BPS;

    logic [ND-1:0]     r_v;
    logic [WW-1:0]     r_rem  [ND];
    logic [QUOT_W-1:0] r_q    [ND];
    logic [7:0]        r_dv   [ND];
    logic [SIDE_W-1:0] r_side [ND];
    logic [WW-1:0]     n_rem  [ND];
    logic [QUOT_W-1:0] n_q    [ND];

    always_comb begin
        logic [WW-1:0]     rem;
        logic [QUOT_W-1:0] q;
        logic [7:0]        dv;
        for (int k = 0; k < ND; k++) begin
            if (k == 0) begin
                rem = i_dividend;
                q   = '0;
                dv  = i_divisor;
            end else begin
                rem = r_rem[k-1];
                q   = r_q[k-1];
                dv  = r_dv[k-1];
            end
            for (int j = 0; j < BPS; j++) begin
                if (k * BPS + j < QUOT_W) begin
                    if (rem >= (WW'(dv) << (QUOT_W - 1 - k * BPS - j))) begin
                        rem = rem - (WW'(dv) << (QUOT_W - 1 - k * BPS - j));
                        q[QUOT_W - 1 - k * BPS - j] = 1'b1;
                    end
                end
            end
            n_rem[k] = rem;
            n_q[k]   = q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < ND; k++) begin
                if (k == 0) begin
                    r_v[k] <= i_valid;
                end else begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
        for (int k = 0; k < ND; k++) begin
            r_rem[k] <= n_rem[k];
            r_q[k]   <= n_q[k];
            if (k == 0) begin
                r_dv[k]   <= i_divisor;
                r_side[k] <= i_side;
            end else begin
                r_dv[k]   <= r_dv[k-1];
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_valid = r_v[ND-1];
    assign o_quot  = r_q[ND-1];
    assign o_side  = r_side[ND-1];

endmodule

>>> sim/tb.sv
// tb: self-checking bench for rgb_hue_rotate, directed pixel table then random pixels
// sweeps the hue shift register and checks every result against a typed value or an in-bench hue predictor
// depends on rhr_pkg and the rgb_hue_rotate rtl
module tb;
    import rhr_pkg::*;

    localparam int HUE_FRAC_BITS   = 4;
    localparam int SECTOR          = SECTOR_DEG << HUE_FRAC_BITS;
    localparam int CIRCLE          = 6 * SECTOR;
    localparam int LATENCY         = (HUE_FRAC_BITS + 7) / 2 + 6;
    localparam int ITEMS_PER_PHASE = 95;
    localparam int NUM_PROBES      = 21;
    localparam int NUM_SHIFTS      = 11;

    typedef struct {
        t_pix_in  px;
        bit       typed;
        t_pix_out want;
    } t_probe;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    t_pix_in            i_pixel;
    logic               o_valid;
    t_pix_out           o_result;
    logic               i_cfg_we;
    logic [SHIFT_W-1:0] i_cfg_data;

    t_pix_out                  pending_pixels[$];
    t_pix_out                  want_pixel;
    logic signed [SHIFT_W-1:0] shift_setting;
    int                        mismatch_count = 0;
    int                        burst_left = 0;

    t_probe probe_table[NUM_PROBES] = '{
        '{'{8'd0,   8'd0,   8'd0},   1'b1, '{8'd0,   8'd0,   8'd0}},
        '{'{8'd255, 8'd255, 8'd255}, 1'b1, '{8'd255, 8'd255, 8'd255}},
        '{'{8'd128, 8'd128, 8'd128}, 1'b1, '{8'd128, 8'd128, 8'd128}},
        '{'{8'd1,   8'd1,   8'd1},   1'b1, '{8'd1,   8'd1,   8'd1}},
        '{'{8'd255, 8'd0,   8'd0},   1'b1, '{8'd255, 8'd0,   8'd0}},
        '{'{8'd0,   8'd255, 8'd0},   1'b1, '{8'd0,   8'd255, 8'd0}},
        '{'{8'd0,   8'd0,   8'd255}, 1'b1, '{8'd0,   8'd0,   8'd255}},
        '{'{8'd255, 8'd255, 8'd0},   1'b0, '{8'd0,   8'd0,   8'd0}},
        '{'{8'd0,   8'd255, 8'd255}, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{'{8'd255, 8'd0,   8'd255}, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{'{8'd255, 8'd254, 8'd0},   1'b0, '{8'd0,   8'd0,   8'd0}},
        '{'{8'd200, 8'd10,  8'd90},  1'b0, '{8'd0,   8'd0,   8'd0}},
        '{'{8'd120, 8'd200, 8'd10},  1'b0, '{8'd0,   8'd0,   8'd0}},
        '{'{8'd10,  8'd200, 8'd150}, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{'{8'd10,  8'd60,  8'd220}, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{'{8'd220, 8'd60,  8'd250}, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{'{8'd0,   8'd200, 8'd200}, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{'{8'd100, 8'd50,  8'd100}, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{'{8'd1,   8'd0,   8'd0},   1'b0, '{8'd0,   8'd0,   8'd0}},
        '{'{8'd170, 8'd85,  8'd0},   1'b0, '{8'd0,   8'd0,   8'd0}},
        '{'{8'd0,   8'd1,   8'd255}, 1'b0, '{8'd0,   8'd0,   8'd0}}
    };

    int shift_plan[NUM_SHIFTS] = '{5759, -5760, 8191, -8192, 1, -1, 2880, -960, 960, 0, 0};

    rgb_hue_rotate #(
        .HUE_FRAC_BITS(HUE_FRAC_BITS)
    ) i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_pixel   (i_pixel),
        .o_valid   (o_valid),
        .o_result  (o_result),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_pix_out rotate_hue(input t_pix_in px,
                                            input logic signed [SHIFT_W-1:0] shift);
        int       r;
        int       g;
        int       b;
        int       mx;
        int       mn;
        int       delta;
        int       hue;
        int       sec;
        int       frac;
        int       pos;
        int       mid;
        t_max_sel top;
        t_pix_out res;
        r = px.in_red;
        g = px.in_green;
        b = px.in_blue;
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        delta = mx - mn;
        if (delta == 0) begin
            res.out_red   = px.in_red;
            res.out_green = px.in_green;
            res.out_blue  = px.in_blue;
            return res;
        end
        top = (r == mx) ? MAX_RED : (g == mx) ? MAX_GREEN : MAX_BLUE;
        case (top)
            MAX_RED: begin
                if (g >= b) hue = SECTOR * (g - b) / delta;
                else        hue = CIRCLE - SECTOR * (b - g) / delta;
            end
            MAX_GREEN: hue = 2 * SECTOR + SECTOR * (b - r) / delta;
            default:   hue = 4 * SECTOR + SECTOR * (r - g) / delta;
        endcase
        hue = (hue + int'(shift)) % CIRCLE;
        if (hue < 0) hue += CIRCLE;
        sec  = hue / SECTOR;
        frac = hue % SECTOR;
        pos  = (sec % 2 == 1) ? SECTOR - frac : frac;
        mid  = mn + (delta * pos) / SECTOR;
        case (sec)
            0:       res = '{8'(mx),  8'(mid), 8'(mn)};
            1:       res = '{8'(mid), 8'(mx),  8'(mn)};
            2:       res = '{8'(mn),  8'(mx),  8'(mid)};
            3:       res = '{8'(mn),  8'(mid), 8'(mx)};
            4:       res = '{8'(mid), 8'(mn),  8'(mx)};
            default: res = '{8'(mx),  8'(mn),  8'(mid)};
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // one pixel transaction, with a random idle gap ahead of it
    task automatic send_pixel(input t_pix_in px, input t_pix_out want);
        int gap;
        if (burst_left > 0) begin
            gap = 0;
            burst_left--;
        end else begin
            gap = $urandom_range(0, 10);
            if ($urandom_range(0, 7) == 0) burst_left = $urandom_range(10, 40);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start   <= 1'b1;
        i_pixel <= px;
        do @(posedge i_clk); while (busy);
        pending_pixels.push_back(want);
    endtask

    task automatic drain_pixels();
        start <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
    endtask

    task automatic program_shift(input logic [SHIFT_W-1:0] value);
        drain_pixels();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we      <= 1'b0;
        shift_setting = value;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", o_result));
            end else begin
                want_pixel = pending_pixels.pop_front();
                if (o_result.out_red !== want_pixel.out_red)
                    report_mismatch($sformatf("red got %0d want %0d",
                                              o_result.out_red, want_pixel.out_red));
                if (o_result.out_green !== want_pixel.out_green)
                    report_mismatch($sformatf("green got %0d want %0d",
                                              o_result.out_green, want_pixel.out_green));
                if (o_result.out_blue !== want_pixel.out_blue)
                    report_mismatch($sformatf("blue got %0d want %0d",
                                              o_result.out_blue, want_pixel.out_blue));
            end
        end
    end

    initial begin
        t_pix_in px;
        int      mode;
        shift_setting = '0;
        shift_plan[NUM_SHIFTS-1] = $urandom_range(0, 16383);
        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_pixel    <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_data <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (probe_table[k])
            send_pixel(probe_table[k].px, probe_table[k].typed ? probe_table[k].want
                       : rotate_hue(probe_table[k].px, shift_setting));

        foreach (shift_plan[s]) begin
            program_shift(shift_plan[s][SHIFT_W-1:0]);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n == ITEMS_PER_PHASE / 2) drain_pixels();
                px = 24'($urandom);
                mode = $urandom_range(0, 9);
                case (mode)
                    0: begin
                        px.in_green = px.in_red;
                        px.in_blue  = px.in_red;
                    end
                    1: begin
                        case ($urandom_range(0, 2))
                            0:       px.in_green = px.in_red;
                            1:       px.in_blue  = px.in_green;
                            default: px.in_blue  = px.in_red;
                        endcase
                    end
                    2: begin
                        px.in_red  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                        px.in_blue = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                    end
                    default: ;
                endcase
                send_pixel(px, rotate_hue(px, shift_setting));
            end
        end

        drain_pixels();
        repeat (LATENCY + 4) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
